@@ hw/rtl/ced_pkg.sv @@
// Shared types, constants and helpers of the cable e-marker discovery unit.
package ced_pkg;

    // PD message header fields
    localparam logic [4:0] MSG_TYPE_VDM     = 5'd15;
    localparam logic [4:0] MSG_TYPE_GOODCRC = 5'd1;
    localparam logic [1:0] REV_30           = 2'd2;
    localparam logic [2:0] ONE_OBJECT       = 3'd1;
    localparam logic [2:0] ZERO_OBJECTS     = 3'd0;

    // VDM header fields
    localparam logic [31:0] VDM_DISCOVER_WORD     = 32'hFF00A001;
    localparam logic [15:0] SVID_PD_SID           = 16'hFF00;
    localparam logic [4:0]  CMD_DISCOVER_IDENTITY = 5'd1;
    localparam logic [1:0]  CMD_TYPE_REQ          = 2'd0;
    localparam logic [1:0]  CMD_TYPE_ACK          = 2'd1;

    // Function codes of an input request
    localparam logic FUNC_ISSUE   = 1'b0;
    localparam logic FUNC_RX_OBJ  = 1'b1;

    // Transmit kinds
    localparam logic [1:0] TX_NONE     = 2'd0;
    localparam logic [1:0] TX_DISCOVER = 2'd1;
    localparam logic [1:0] TX_GOODCRC  = 2'd2;

    // Identity word storage
    localparam int         ID_WORDS      = 6;
    localparam int         ID_IDX_W      = 3;
    localparam int         CABLE_VDO_IDX = 3;
    localparam logic [2:0] LAST_ID_OBJ   = 3'd6;

    // Cable limits
    localparam logic [1:0]  CUR_CODE_5A = 2'd2;
    localparam logic [12:0] CURRENT_5A  = 13'd5000;
    localparam logic [12:0] CURRENT_3A  = 13'd3000;

    typedef struct packed {
        logic        func;
        logic [15:0] msg_header;
        logic [2:0]  obj_index;
        logic [31:0] obj_data;
        logic        obj_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  tx_kind;
        logic [15:0] tx_header;
        logic [31:0] tx_vdm_word;
        logic        cable_active;
        logic [12:0] max_current_ma;
        logic [15:0] max_voltage_mv;
        logic [31:0] id_header_vdo;
        logic [31:0] cert_stat_vdo;
        logic [31:0] product_vdo;
        logic [31:0] cable_vdo_one;
        logic [31:0] cable_vdo_two;
        logic [31:0] alt_mode_vdo;
    } out_item_t;

    // Build a PD message header
    function automatic logic [15:0] make_header(
        input logic [4:0] mtype,
        input logic [1:0] rev,
        input logic [2:0] id,
        input logic [2:0] nobj
    );
        return {1'b0, nobj, id, 1'b0, rev, 1'b0, mtype};
    endfunction

    // Voltage limit from cable VDO bits 10:9
    function automatic logic [15:0] voltage_limit(input logic [1:0] code);
        logic [15:0] mv;
        case (code)
            2'd0:    mv = 16'd20000;
            2'd1:    mv = 16'd30000;
            2'd2:    mv = 16'd40000;
            default: mv = 16'd50000;
        endcase
        return mv;
    endfunction

endpackage

@@ hw/rtl/ced_if.sv @@
// Valid/ready channel interfaces for input requests and results.
interface ced_in_if;
    import ced_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ced_out_if;
    import ced_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/cable_emarker_discovery_unit.sv @@
// SOP' Discover Identity engine: request issue, ACK capture, GoodCRC reply.
//
//  channel  | dir | payload      | request moves when
//  ---------+-----+--------------+-----------------------------
//  item     | in  | in_item_t    | item.valid && item.ready
//  result   | out | out_item_t   | result.valid && result.ready
//
// One result per request, held in the result register.
// A request is taken every cycle unless item.ready is low; the state update
// and field checks sit between the input handshake and the result register.
// item.ready drops only while a result waits and result.ready is low.
// Reset clears the message ID, flags, stored identity words and result valid.
module cable_emarker_discovery_unit (
    input  logic            clk,
    input  logic            rst_n,
    ced_in_if.sink          item,
    ced_out_if.source       result
);
    import ced_pkg::*;

    logic [2:0]  next_msg_id_reg, next_msg_id_next;
    logic        active_reg, active_next;
    logic        resp_seen_reg, resp_seen_next;
    logic        ack_seen_reg, ack_seen_next;
    logic [31:0] words_reg [ID_WORDS];
    logic [31:0] words_next [ID_WORDS];
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic        accept;
    logic [4:0]  rx_type;
    logic [1:0]  rx_rev;
    logic [2:0]  rx_id;
    logic [2:0]  rx_nobj;
    logic [1:0]  rx_ctype;
    logic        store_en;
    logic [1:0]  tx_kind;
    logic [15:0] tx_header;
    logic [31:0] tx_vdm;
    logic [31:0] cable_vdo;

    assign accept     = item.valid && item.ready;
    assign item.ready = !out_valid_reg || result.ready;

    // Received header and VDM fields
    assign rx_type  = item.data.msg_header[4:0];
    assign rx_rev   = item.data.msg_header[7:6];
    assign rx_id    = item.data.msg_header[11:9];
    assign rx_nobj  = item.data.msg_header[14:12];
    assign rx_ctype = item.data.obj_data[7:6];

    // Identity objects of an ACK within the object count
    assign store_en = (item.data.func == FUNC_RX_OBJ) && ack_seen_reg
                      && (item.data.obj_index != 3'd0)
                      && (item.data.obj_index <= LAST_ID_OBJ)
                      && (item.data.obj_index < rx_nobj);

    // State update for one request
    always_comb
    begin
        next_msg_id_next = next_msg_id_reg;
        active_next      = active_reg;
        resp_seen_next   = resp_seen_reg;
        ack_seen_next    = ack_seen_reg;
        tx_kind          = TX_NONE;
        tx_header        = 16'd0;
        tx_vdm           = 32'd0;
        for (int w = 0; w < ID_WORDS; w++)
        begin
            words_next[w] = words_reg[w];
            if (accept && store_en && (item.data.obj_index == ID_IDX_W'(w + 1)))
            begin
                words_next[w] = item.data.obj_data;
            end
        end

        if (accept)
        begin
            if (item.data.func == FUNC_ISSUE)
            begin
                active_next      = 1'b0;
                resp_seen_next   = 1'b0;
                ack_seen_next    = 1'b0;
                tx_kind          = TX_DISCOVER;
                tx_header        = make_header(MSG_TYPE_VDM, REV_30, next_msg_id_reg,
                                               ONE_OBJECT);
                tx_vdm           = VDM_DISCOVER_WORD;
                next_msg_id_next = next_msg_id_reg + 3'd1;
            end
            else
            begin
                // VDM header object sets the seen flags
                if (item.data.obj_index == 3'd0)
                begin
                    resp_seen_next = (rx_type == MSG_TYPE_VDM) && (rx_nobj != 3'd0)
                                     && (rx_ctype != CMD_TYPE_REQ);
                    ack_seen_next  = resp_seen_next
                                     && (item.data.obj_data[31:16] == SVID_PD_SID)
                                     && (item.data.obj_data[4:0] == CMD_DISCOVER_IDENTITY)
                                     && (rx_ctype == CMD_TYPE_ACK);
                end

                // Message end: activate and acknowledge
                if (item.data.obj_last)
                begin
                    if (ack_seen_next && (rx_nobj > 3'd1))
                    begin
                        active_next = 1'b1;
                    end
                    if (resp_seen_next && (rx_id == next_msg_id_reg - 3'd1))
                    begin
                        tx_kind   = TX_GOODCRC;
                        tx_header = make_header(MSG_TYPE_GOODCRC, rx_rev, rx_id,
                                                ZERO_OBJECTS);
                    end
                    resp_seen_next = 1'b0;
                    ack_seen_next  = 1'b0;
                end
            end
        end
    end

    // Result snapshot after the update
    assign cable_vdo = words_next[CABLE_VDO_IDX];

    always_comb
    begin
        out_data_next.tx_kind        = tx_kind;
        out_data_next.tx_header      = tx_header;
        out_data_next.tx_vdm_word    = tx_vdm;
        out_data_next.cable_active   = active_next;
        out_data_next.max_current_ma = !active_next ? 13'd0 :
                                       (cable_vdo[6:5] == CUR_CODE_5A) ? CURRENT_5A
                                                                       : CURRENT_3A;
        out_data_next.max_voltage_mv = active_next ? voltage_limit(cable_vdo[10:9])
                                                   : 16'd0;
        out_data_next.id_header_vdo  = words_next[0];
        out_data_next.cert_stat_vdo  = words_next[1];
        out_data_next.product_vdo    = words_next[2];
        out_data_next.cable_vdo_one  = words_next[3];
        out_data_next.cable_vdo_two  = words_next[4];
        out_data_next.alt_mode_vdo   = words_next[5];
    end

    // Result valid
    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and identity state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_msg_id_reg <= 3'd0;
            active_reg      <= 1'b0;
            resp_seen_reg   <= 1'b0;
            ack_seen_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int w = 0; w < ID_WORDS; w++)
            begin
                words_reg[w] <= 32'd0;
            end
        end
        else
        begin
            next_msg_id_reg <= next_msg_id_next;
            active_reg      <= active_next;
            resp_seen_reg   <= resp_seen_next;
            ack_seen_reg    <= ack_seen_next;
            out_valid_reg   <= out_valid_next;
            for (int w = 0; w < ID_WORDS; w++)
            begin
                words_reg[w] <= words_next[w];
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

`ifndef SYNTHESIS
    // ACK flag never stands without the response flag
    assert property (@(posedge clk) disable iff (!rst_n)
        ack_seen_reg |-> resp_seen_reg)
        else $error("ack flag set without response flag");

    // Issue or message end leaves no stale flags
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && ((item.data.func == FUNC_ISSUE) || item.data.obj_last)
        |=> !resp_seen_reg && !ack_seen_reg)
        else $error("seen flags survived message end");

    // Issue advances the message ID
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.data.func == FUNC_ISSUE)
        |=> next_msg_id_reg == $past(next_msg_id_reg) + 3'd1)
        else $error("message ID did not advance");

    // Limits read zero while inactive
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.data.cable_active
        |-> (result.data.max_current_ma == 13'd0) && (result.data.max_voltage_mv == 16'd0))
        else $error("limits nonzero while inactive");

    // Only an issue produces a discover request
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.data.func == FUNC_RX_OBJ)
        |=> result.data.tx_kind != TX_DISCOVER)
        else $error("discover request from received object");
`endif

endmodule

@@ bench/tb_cable_emarker_discovery_unit.sv @@
// Self-checking testbench of the SOP' cable e-marker discovery unit.
module tb_cable_emarker_discovery_unit;
    import ced_pkg::*;

    localparam int          TOTAL_ITEMS  = 1050;
    localparam int          PHASE_ITEMS  = 150;
    localparam int          QUIET_LIMIT  = 2000;
    localparam int          END_SETTLE   = 8;
    localparam logic [1:0]  CMD_TYPE_NAK = 2'd2;
    localparam logic [31:0] ACK_WORD     =
        {SVID_PD_SID, 8'h00, CMD_TYPE_ACK, 1'b0, CMD_DISCOVER_IDENTITY};

    // Expected-result tracker: own copy of the identity engine state
    class identity_scoreboard;
        logic [2:0]  msg_id_next;
        bit          active;
        logic [31:0] words [ID_WORDS];
        bit          resp_seen;
        bit          ack_seen;
        out_item_t   expected_results [$];
        int          errors;
        int          n_checked;
        int          n_discover;
        int          n_goodcrc;
        int          n_captures;

        function new();
            msg_id_next = '0;
            active      = 0;
            resp_seen   = 0;
            ack_seen    = 0;
            foreach (words[i]) words[i] = '0;
            errors      = 0;
            n_checked   = 0;
            n_discover  = 0;
            n_goodcrc   = 0;
            n_captures  = 0;
        endfunction

        static function logic [15:0] pd_header(input logic [4:0] mtype, input logic [1:0] rev,
                                               input logic [2:0] id, input logic [2:0] nobj);
            logic [15:0] h;
            h        = '0;
            h[4:0]   = mtype;
            h[7:6]   = rev;
            h[11:9]  = id;
            h[14:12] = nobj;
            return h;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Advance the engine state by one request and return its result
        function out_item_t predict_identity(input in_item_t it);
            out_item_t   r;
            logic [4:0]  mtype;
            logic [1:0]  rev;
            logic [1:0]  ctype;
            logic [2:0]  mid;
            logic [2:0]  nobj;
            logic [2:0]  prev_id;
            logic [31:0] cable;
            r = '0;
            if (it.func == FUNC_ISSUE) begin
                active        = 0;
                resp_seen     = 0;
                ack_seen      = 0;
                r.tx_kind     = TX_DISCOVER;
                r.tx_header   = pd_header(MSG_TYPE_VDM, REV_30, msg_id_next, 3'd1);
                r.tx_vdm_word = VDM_DISCOVER_WORD;
                msg_id_next   = msg_id_next + 3'd1;
                n_discover++;
            end else begin
                mtype = it.msg_header[4:0];
                rev   = it.msg_header[7:6];
                mid   = it.msg_header[11:9];
                nobj  = it.msg_header[14:12];
                if (it.obj_index == 3'd0) begin
                    ctype     = it.obj_data[7:6];
                    resp_seen = (mtype == MSG_TYPE_VDM) && (nobj != 3'd0) &&
                                (ctype != CMD_TYPE_REQ);
                    ack_seen  = resp_seen && (it.obj_data[31:16] == SVID_PD_SID) &&
                                (it.obj_data[4:0] == CMD_DISCOVER_IDENTITY) &&
                                (ctype == CMD_TYPE_ACK);
                end else if (it.obj_index <= LAST_ID_OBJ) begin
                    if (ack_seen && it.obj_index < nobj)
                        words[it.obj_index - 3'd1] = it.obj_data;
                end
                // message end: capture and acknowledge
                if (it.obj_last) begin
                    if (ack_seen && nobj > 3'd1) begin
                        if (!active) n_captures++;
                        active = 1;
                    end
                    prev_id = msg_id_next - 3'd1;
                    if (resp_seen && mid == prev_id) begin
                        r.tx_kind   = TX_GOODCRC;
                        r.tx_header = pd_header(MSG_TYPE_GOODCRC, rev, mid, 3'd0);
                        n_goodcrc++;
                    end
                    resp_seen = 0;
                    ack_seen  = 0;
                end
            end
            // identity snapshot after the update
            cable          = words[CABLE_VDO_IDX];
            r.cable_active = active;
            if (active) begin
                r.max_current_ma = (cable[6:5] == CUR_CODE_5A) ? CURRENT_5A : CURRENT_3A;
                case (cable[10:9])
                    2'd0:    r.max_voltage_mv = 16'd20000;
                    2'd1:    r.max_voltage_mv = 16'd30000;
                    2'd2:    r.max_voltage_mv = 16'd40000;
                    default: r.max_voltage_mv = 16'd50000;
                endcase
            end
            r.id_header_vdo = words[0];
            r.cert_stat_vdo = words[1];
            r.product_vdo   = words[2];
            r.cable_vdo_one = words[3];
            r.cable_vdo_two = words[4];
            r.alt_mode_vdo  = words[5];
            return r;
        endfunction

        function void note_request(input in_item_t it);
            expected_results.push_back(predict_identity(it));
        endfunction

        task report_error(input string msg);
            errors++;
            if (errors <= 100)
                $display("ERROR: %s", msg);
        endtask

        task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
            if (got !== want)
                report_error($sformatf("result %0d %s: got %h, expected %h",
                                       n_checked, name, got, want));
        endtask

        task check_result(input out_item_t got);
            out_item_t want;
            if (expected_results.size() == 0) begin
                report_error($sformatf("result %0d arrived with no request pending", n_checked));
            end else begin
                want = expected_results.pop_front();
                compare_field("tx_kind", 32'(got.tx_kind), 32'(want.tx_kind));
                compare_field("tx_header", 32'(got.tx_header), 32'(want.tx_header));
                compare_field("tx_vdm_word", got.tx_vdm_word, want.tx_vdm_word);
                compare_field("cable_active", 32'(got.cable_active), 32'(want.cable_active));
                compare_field("max_current_ma", 32'(got.max_current_ma),
                              32'(want.max_current_ma));
                compare_field("max_voltage_mv", 32'(got.max_voltage_mv),
                              32'(want.max_voltage_mv));
                compare_field("id_header_vdo", got.id_header_vdo, want.id_header_vdo);
                compare_field("cert_stat_vdo", got.cert_stat_vdo, want.cert_stat_vdo);
                compare_field("product_vdo", got.product_vdo, want.product_vdo);
                compare_field("cable_vdo_one", got.cable_vdo_one, want.cable_vdo_one);
                compare_field("cable_vdo_two", got.cable_vdo_two, want.cable_vdo_two);
                compare_field("alt_mode_vdo", got.alt_mode_vdo, want.alt_mode_vdo);
            end
            n_checked++;
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    ced_in_if           item_ch ();
    ced_out_if          result_ch ();
    identity_scoreboard sb;

    bit                 idle_on;
    int                 items_sent;
    int                 quiet_cycles;
    logic [2:0]         last_issued_id;

    cable_emarker_discovery_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Gap length: mostly none, often short, rarely long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one request and hold it until taken; then maybe idle
    task automatic send_item(input in_item_t it);
        int unsigned gap;
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        items_sent++;
        if (it.func == FUNC_ISSUE) last_issued_id = last_issued_id + 3'd1;
        gap = idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_issue();
        in_item_t it;
        it.func       = FUNC_ISSUE;
        it.msg_header = 16'($urandom_range(16'hFFFF));
        it.obj_index  = 3'($urandom_range(7));
        it.obj_data   = $urandom;
        it.obj_last   = 1'($urandom_range(1));
        send_item(it);
    endtask

    task automatic send_obj(input logic [15:0] hdr, input logic [2:0] idx,
                            input logic [31:0] data, input logic last);
        in_item_t it;
        it.func       = FUNC_RX_OBJ;
        it.msg_header = hdr;
        it.obj_index  = idx;
        it.obj_data   = data;
        it.obj_last   = last;
        send_item(it);
    endtask

    // Hold off the sender until every result is back
    task automatic drain_results();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // One random exchange: optional discover, then a mostly well-formed reply
    task automatic random_exchange();
        logic [15:0] hdr;
        logic [2:0]  nobj;
        logic [31:0] vdm0;
        int          first;
        int          stop;
        int          n;
        int unsigned shape;
        int unsigned flavor;
        if ($urandom_range(3) != 0) send_issue();
        nobj = ($urandom_range(4) != 0) ? 3'($urandom_range(2, 7)) : 3'($urandom_range(1));
        hdr  = 16'($urandom_range(16'hFFFF));
        if ($urandom_range(9) != 0) hdr[4:0] = MSG_TYPE_VDM;
        hdr[11:9]  = ($urandom_range(4) != 0) ? last_issued_id : 3'($urandom_range(7));
        hdr[14:12] = nobj;
        vdm0   = $urandom;
        flavor = $urandom_range(9);
        if (flavor < 6) begin
            vdm0[31:16] = SVID_PD_SID;
            vdm0[4:0]   = CMD_DISCOVER_IDENTITY;
            vdm0[7:6]   = CMD_TYPE_ACK;
        end else if (flavor < 8) begin
            vdm0[31:16] = SVID_PD_SID;
            vdm0[4:0]   = CMD_DISCOVER_IDENTITY;
        end
        first = 0;
        stop  = (nobj == 3'd0) ? 0 : nobj - 1;
        shape = $urandom_range(11);
        if (shape == 0) first = $urandom_range(1, 6);
        if (shape == 1) stop = $urandom_range(0, 7);
        if (stop < first) stop = first;
        for (n = first; n <= stop; n++) begin
            // abort by a discover just before the closing object
            if (shape == 2 && n == stop && n > first) send_issue();
            send_obj(hdr, n[2:0], (n == 0) ? vdm0 : $urandom, n == stop);
        end
    endtask

    task automatic send_noise();
        in_item_t it;
        it.func       = 1'($urandom_range(1));
        it.msg_header = 16'($urandom_range(16'hFFFF));
        it.obj_index  = 3'($urandom_range(7));
        it.obj_data   = $urandom;
        it.obj_last   = 1'($urandom_range(1));
        send_item(it);
    endtask

    // Result sink with random stalls
    initial begin : result_sink
        int unsigned stall;
        stall = 0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall != 0) begin
                stall--;
                result_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(3) == 0) begin
                stall = pick_gap();
                result_ch.ready <= (stall == 0);
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: check results first, then log newly taken requests
    always @(posedge clk) begin
        if (result_ch.valid && result_ch.ready)
            sb.check_result(result_ch.data);
        if (item_ch.valid && item_ch.ready)
            sb.note_request(item_ch.data);
        if ((result_ch.valid && result_ch.ready) || (item_ch.valid && item_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog on handshake activity
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("Timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [15:0] h;
        int          phase;
        int          next_phase_at;
        sb             = new();
        idle_on        = 1;
        items_sent     = 0;
        last_issued_id = 3'd7;
        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reply before any discover: ID matches the wrapped value
        h = identity_scoreboard::pd_header(MSG_TYPE_VDM, REV_30, last_issued_id, 3'd1);
        send_obj(h, 3'd0, ACK_WORD, 1'b1);

        // full seven-object ACK, 5 A / 50 V cable
        send_issue();
        h = identity_scoreboard::pd_header(MSG_TYPE_VDM, REV_30, last_issued_id, 3'd7);
        send_obj(h, 3'd0, ACK_WORD, 1'b0);
        send_obj(h, 3'd1, 32'hFFFF_FFFF, 1'b0);
        send_obj(h, 3'd2, 32'h0000_0000, 1'b0);
        send_obj(h, 3'd3, 32'h1234_5678, 1'b0);
        send_obj(h, 3'd4, 32'h0000_0640, 1'b0);
        send_obj(h, 3'd5, 32'hA5A5_5A5A, 1'b0);
        send_obj(h, 3'd6, 32'h8000_0001, 1'b1);

        // ACK with wrong message ID: captured, no GoodCRC
        send_issue();
        h = identity_scoreboard::pd_header(MSG_TYPE_VDM, 2'd1, last_issued_id + 3'd4, 3'd3);
        send_obj(h, 3'd0, ACK_WORD, 1'b0);
        send_obj(h, 3'd1, 32'h0F0F_0F0F, 1'b0);
        send_obj(h, 3'd2, 32'hF0F0_F0F0, 1'b1);

        // NAK gets GoodCRC only; a request type gets nothing
        h = identity_scoreboard::pd_header(MSG_TYPE_VDM, REV_30, last_issued_id, 3'd1);
        send_obj(h, 3'd0, {SVID_PD_SID, 8'h00, CMD_TYPE_NAK, 1'b0, CMD_DISCOVER_IDENTITY}, 1'b1);
        send_obj(h, 3'd0, {SVID_PD_SID, 8'h00, CMD_TYPE_REQ, 1'b0, CMD_DISCOVER_IDENTITY}, 1'b1);

        // foreign SVID: response but no capture
        h = identity_scoreboard::pd_header(MSG_TYPE_VDM, REV_30, last_issued_id, 3'd2);
        send_obj(h, 3'd0, {16'h1234, ACK_WORD[15:0]}, 1'b0);
        send_obj(h, 3'd1, 32'hDEAD_BEEF, 1'b1);

        // index past the count is dropped, index seven closes
        send_obj(h, 3'd0, ACK_WORD, 1'b0);
        send_obj(h, 3'd3, 32'h0BAD_0BAD, 1'b0);
        send_obj(h, 3'd7, 32'hFFFF_FFFF, 1'b1);

        // object with no object zero ahead of it
        send_obj(h, 3'd1, 32'h5555_5555, 1'b1);

        // discover in the middle of a reply aborts it
        send_obj(h, 3'd0, ACK_WORD, 1'b0);
        send_issue();
        send_obj(h, 3'd1, 32'h7777_7777, 1'b1);

        // field extremes
        send_obj(16'hFFFF, 3'd0, 32'hFFFF_FFFF, 1'b1);
        send_obj(16'h0000, 3'd7, 32'h0000_0000, 1'b0);
        drain_results();

        // random exchanges in phases; idling off in every third phase
        phase         = 0;
        next_phase_at = items_sent + PHASE_ITEMS;
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent >= next_phase_at) begin
                drain_results();
                phase++;
                idle_on       = (phase % 3 != 1);
                next_phase_at = items_sent + PHASE_ITEMS;
            end
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3)) send_noise();
            else
                random_exchange();
        end

        drain_results();
        repeat (END_SETTLE) @(posedge clk);

        $display("Run covered %0d requests (%0d discover issues), %0d results checked",
                 items_sent, sb.n_discover, sb.n_checked);
        $display("Replies acknowledged: %0d, identity captures: %0d",
                 sb.n_goodcrc, sb.n_captures);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
